>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the blur datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg
// Types and constants of the 3x3 Gaussian blur unit.
// ----------------------------------------------------------------------------
package gb3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int COEF_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int SUM_W      = 10;   // four pixels summed

  localparam int OFIFO_DEPTH = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CORNER  = 3'd4;

  // reset values (sigma 1 mask)
  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [COEF_W-1:0] RST_COEF_CENTER  = 16'd13381;
  localparam logic [COEF_W-1:0] RST_COEF_EDGE    = 16'd8116;
  localparam logic [COEF_W-1:0] RST_COEF_CORNER  = 16'd4922;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_item_t;

  // one line buffer entry: two rows above the current one
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } pair_t;

  // item held in the first stage
  typedef struct packed {
    logic             valid;
    logic             col_zero;
    logic             row_ge1;
    logic             row_ge2;
    logic             last;
    logic             flush;
    logic [PIX_W-1:0] pix;
  } s1_t;

  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [SUM_W-1:0] orth;
    logic [SUM_W-1:0] diag;
  } sums_t;

  // window sums for the inner result (a) and the row-end result (b)
  typedef struct packed {
    logic  valid;
    logic  has_a;
    logic  has_b;
    logic  frame_last;
    sums_t a;
    sums_t b;
  } s2_t;

  typedef struct packed {
    logic      a_valid;
    out_item_t a;
    logic      b_valid;
    out_item_t b;
  } push_t;

endpackage

>>> hdl/gb3_line_buf.sv
// ----------------------------------------------------------------------------
// gb3_line_buf
// Two-row line buffer with registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module gb3_line_buf #(
  parameter int DEPTH = gb3_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  gb3_pkg::pair_t           wr_data,
  output gb3_pkg::pair_t           rd_data
);

  gb3_pkg::pair_t mem [DEPTH];
  gb3_pkg::pair_t rd_q_r;
  gb3_pkg::pair_t byp_data_r;
  logic           byp_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // a read that collides with the write of the same edge takes the new word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

>>> hdl/gb3_window.sv
// ----------------------------------------------------------------------------
// gb3_window
// 3x3 pixel window and the neighbor sums for the two possible results.
// ----------------------------------------------------------------------------
module gb3_window (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  gb3_pkg::s1_t   s1,
  input  gb3_pkg::pair_t rd,
  output gb3_pkg::s2_t   s2
);

  typedef struct packed {
    logic [gb3_pkg::PIX_W-1:0] up;
    logic [gb3_pkg::PIX_W-1:0] mid;
    logic [gb3_pkg::PIX_W-1:0] cur;
  } wcol_t;

  wcol_t        win0_r, win1_r, win2_r;
  wcol_t        nw0, nw1, nw2;
  gb3_pkg::s2_t s2_r, s2_nxt;

  function automatic logic [gb3_pkg::SUM_W-1:0] ext(input logic [gb3_pkg::PIX_W-1:0] p);
    ext = gb3_pkg::SUM_W'(p);
  endfunction

  always_comb begin
    nw2.up  = s1.row_ge2 ? rd.upper  : '0;
    nw2.mid = s1.row_ge1 ? rd.middle : '0;
    nw2.cur = s1.pix;
    // a new row starts from an empty window
    if (s1.col_zero) begin
      nw0 = '0;
      nw1 = '0;
    end else begin
      nw0 = win1_r;
      nw1 = win2_r;
    end

    s2_nxt.valid      = s1.valid;
    s2_nxt.has_a      = s1.row_ge1 && !s1.col_zero;
    s2_nxt.has_b      = s1.row_ge1 && s1.last;
    s2_nxt.frame_last = s1.flush;

    s2_nxt.a.center = nw1.mid;
    s2_nxt.a.orth   = ext(nw1.up) + ext(nw1.cur) + ext(nw0.mid) + ext(nw2.mid);
    s2_nxt.a.diag   = ext(nw0.up) + ext(nw0.cur) + ext(nw2.up) + ext(nw2.cur);

    // right column lies outside the frame
    s2_nxt.b.center = nw2.mid;
    s2_nxt.b.orth   = ext(nw2.up) + ext(nw2.cur) + ext(nw1.mid);
    s2_nxt.b.diag   = ext(nw1.up) + ext(nw1.cur);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
      win2_r <= '0;
      s2_r   <= '0;
    end else if (adv) begin
      s2_r <= s2_nxt;
      if (s1.valid) begin
        win0_r <= nw0;
        win1_r <= nw1;
        win2_r <= nw2;
      end
    end
  end

  assign s2 = s2_r;

endmodule

>>> hdl/gb3_mac.sv
// ----------------------------------------------------------------------------
// gb3_mac
// Weight products, rounding and saturation of the window sums.
// ----------------------------------------------------------------------------
module gb3_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  gb3_pkg::s2_t                s2,
  input  logic [gb3_pkg::COEF_W-1:0]  coef_center,
  input  logic [gb3_pkg::COEF_W-1:0]  coef_edge,
  input  logic [gb3_pkg::COEF_W-1:0]  coef_corner,
  output gb3_pkg::push_t              push
);

  localparam int PC_W  = gb3_pkg::PIX_W + gb3_pkg::COEF_W;
  localparam int PS_W  = gb3_pkg::SUM_W + gb3_pkg::COEF_W;
  localparam int ACC_W = PS_W + 2;
  localparam int FRAC  = gb3_pkg::COEF_W;

  typedef struct packed {
    logic [PC_W-1:0] pc;
    logic [PS_W-1:0] po;
    logic [PS_W-1:0] pd;
  } prod_t;

  typedef struct packed {
    logic  valid;
    logic  has_a;
    logic  has_b;
    logic  frame_last;
    prod_t a;
    prod_t b;
  } s3_t;

  s3_t s3_r, s3_nxt;

  function automatic prod_t mul(input gb3_pkg::sums_t s,
                                input logic [gb3_pkg::COEF_W-1:0] c,
                                input logic [gb3_pkg::COEF_W-1:0] e,
                                input logic [gb3_pkg::COEF_W-1:0] k);
    prod_t p;
    p.pc = PC_W'(s.center) * PC_W'(c);
    p.po = PS_W'(s.orth) * PS_W'(e);
    p.pd = PS_W'(s.diag) * PS_W'(k);
    return p;
  endfunction

  // add one half, drop the fraction, clip to the pixel range
  function automatic logic [gb3_pkg::PIX_W-1:0] finish(input prod_t p);
    logic [ACC_W-1:0]      acc;
    logic [ACC_W-FRAC-1:0] res;
    acc = ACC_W'(p.pc) + ACC_W'(p.po) + ACC_W'(p.pd) + ACC_W'(1 << (FRAC - 1));
    res = acc[ACC_W-1:FRAC];
    if (|res[ACC_W-FRAC-1:gb3_pkg::PIX_W]) begin
      return '1;
    end
    return res[gb3_pkg::PIX_W-1:0];
  endfunction

  always_comb begin
    s3_nxt.valid      = s2.valid;
    s3_nxt.has_a      = s2.has_a;
    s3_nxt.has_b      = s2.has_b;
    s3_nxt.frame_last = s2.frame_last;
    s3_nxt.a          = mul(s2.a, coef_center, coef_edge, coef_corner);
    s3_nxt.b          = mul(s2.b, coef_center, coef_edge, coef_corner);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  always_comb begin
    push.a_valid      = adv && s3_r.valid && s3_r.has_a;
    push.a.pixel_out  = finish(s3_r.a);
    push.a.frame_last = 1'b0;
    push.b_valid      = adv && s3_r.valid && s3_r.has_b;
    push.b.pixel_out  = finish(s3_r.b);
    push.b.frame_last = s3_r.frame_last;
  end

endmodule

>>> hdl/gb3_out_fifo.sv
// ----------------------------------------------------------------------------
// gb3_out_fifo
// Small result queue taking up to two words a cycle, one out unless out_stall.
// ----------------------------------------------------------------------------
module gb3_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  gb3_pkg::push_t      push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_stall,
  output gb3_pkg::out_item_t  out_data
);

  `include "assert_macros.svh"

  localparam int DEPTH = gb3_pkg::OFIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  gb3_pkg::out_item_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] b_addr;
  logic [1:0]    push_n;
  logic          pop;

  assign pop    = out_valid && !out_stall;
  assign push_n = 2'(push.a_valid) + 2'(push.b_valid);
  assign b_addr = wr_ptr_r + PW'(push.a_valid);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      mem[wr_ptr_r] <= push.a;
    end
    if (push.b_valid) begin
      mem[b_addr] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // room for a full burst of two
  assign space_ok  = count_r <= CW'(DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rd_ptr_r];

  `ASSERT_ALWAYS(a_no_overflow, clk, rst_n, (int'(count_r) + int'(push_n)) <= DEPTH, "result queue overflow")
  `ASSERT_IMPLIES(a_push_room, clk, rst_n, push.a_valid || push.b_valid, space_ok, "push without room")

endmodule

>>> hdl/gaussian_blur_3x3_unit.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_unit
// Raster-order 3x3 Gaussian smoothing of 8-bit grayscale frames.
//
//   channel | dir | handshake            | word
//   in      | in  | in_valid / in_stall  | in_data  (req_type, pixel_in)
//   out     | out | out_valid / out_stall| out_data (pixel_out, frame_last)
//   cfg     | in  | cfg_we               | cfg_index, cfg_wdata
//
// One pixel is taken every clock unless in_stall is high; the pixel that
// completes a result word passes the line buffer read, window, multiply and
// result queue registers. The last pixel of a row releases two words, taken one
// a clock unless out_stall is high, from a four-entry queue; in_stall rises
// while that queue holds more than two words. Reset is synchronous; line
// buffers are not cleared: every entry used is written earlier in its frame.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_unit #(
  parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gb3_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gb3_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  `include "assert_macros.svh"

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > gb3_pkg::SIZE_W) ?
                          $clog2(MAX_WIDTH + 1) : gb3_pkg::SIZE_W;
  localparam int HCMP_W = (ROW_W > gb3_pkg::SIZE_W) ? ROW_W : gb3_pkg::SIZE_W;

  logic [gb3_pkg::SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [gb3_pkg::COEF_W-1:0] coef_center_r, coef_edge_r, coef_corner_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [WCMP_W-1:0] w_eff;
  logic [HCMP_W-1:0] h_eff;
  logic              last_col, flush, accept, adv;

  gb3_pkg::s1_t      s1_r, s1_nxt;
  logic [COL_W-1:0]  s1_idx_r;
  gb3_pkg::pair_t    rd_pair, wr_pair;
  gb3_pkg::s2_t      s2;
  gb3_pkg::push_t    push;
  logic              space_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= gb3_pkg::RST_FRAME_WIDTH;
      frame_height_r <= gb3_pkg::RST_FRAME_HEIGHT;
      coef_center_r  <= gb3_pkg::RST_COEF_CENTER;
      coef_edge_r    <= gb3_pkg::RST_COEF_EDGE;
      coef_corner_r  <= gb3_pkg::RST_COEF_CORNER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gb3_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[gb3_pkg::SIZE_W-1:0];
        gb3_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[gb3_pkg::SIZE_W-1:0];
        gb3_pkg::REG_COEF_CENTER:  coef_center_r  <= cfg_wdata;
        gb3_pkg::REG_COEF_EDGE:    coef_edge_r    <= cfg_wdata;
        gb3_pkg::REG_COEF_CORNER:  coef_corner_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp frame sizes to 1..MAX
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WCMP_W'(1);
    end else if (WCMP_W'(frame_width_r) > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = WCMP_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HCMP_W'(1);
    end else if (HCMP_W'(frame_height_r) > HCMP_W'(MAX_HEIGHT)) begin
      h_eff = HCMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = HCMP_W'(frame_height_r);
    end
  end

  assign adv      = space_ok;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  assign last_col = (WCMP_W'(col_r) + WCMP_W'(1)) >= w_eff;
  assign flush    = HCMP_W'(row_r) >= h_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = flush ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    s1_nxt.valid    = accept;
    s1_nxt.col_zero = col_r == '0;
    s1_nxt.row_ge1  = row_r != '0;
    s1_nxt.row_ge2  = HCMP_W'(row_r) >= HCMP_W'(2);
    s1_nxt.last     = last_col;
    s1_nxt.flush    = flush;
    // padding and flush-row items enter as black
    s1_nxt.pix      = (flush || in_data.req_type) ? '0 : in_data.pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (adv) begin
        s1_r <= s1_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r <= col_r;
    end
  end

  // shift the column down one row in the buffer
  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_r.pix;

  gb3_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col_r),
    .wr_en   (adv && s1_r.valid),
    .wr_addr (s1_idx_r),
    .wr_data (wr_pair),
    .rd_data (rd_pair)
  );

  gb3_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .s1    (s1_r),
    .rd    (rd_pair),
    .s2    (s2)
  );

  gb3_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .s2          (s2),
    .coef_center (coef_center_r),
    .coef_edge   (coef_edge_r),
    .coef_corner (coef_corner_r),
    .push        (push)
  );

  gb3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ASSERT_NEXT(a_col_wrap, clk, rst_n, accept && last_col, col_r == '0, "column did not wrap at row end")
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, !adv && s1_r.valid, $stable(s1_r), "first stage moved while frozen")

endmodule

>>> verif/blur_check_pkg.sv
// ----------------------------------------------------------------------------
// blur_check_pkg
// Scoreboard for the 3x3 Gaussian blur unit: tracks the frame position, the
// two line buffers and the 3x3 window, works out the smoothed words that each
// accepted pixel releases and compares them with the words the unit sends.
// ----------------------------------------------------------------------------
package blur_check_pkg;

  import gb3_pkg::*;

  localparam int unsigned LINE_MAX = DEF_MAX_WIDTH;
  localparam int unsigned ROWS_MAX = DEF_MAX_HEIGHT;

  // a size of zero acts as one, anything above the maximum as the maximum
  function automatic int unsigned effective_size(int unsigned v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  class blur_scoreboard;
    int unsigned          width_reg;
    int unsigned          height_reg;
    bit [COEF_W-1:0]      k_center;
    bit [COEF_W-1:0]      k_edge;
    bit [COEF_W-1:0]      k_corner;
    bit [PIX_W-1:0]       two_up [LINE_MAX];
    bit [PIX_W-1:0]       one_up [LINE_MAX];
    bit [PIX_W-1:0]       win [4][3];  // oldest column first, rows top down; column 3 stays zero
    int unsigned          col_cnt;
    int unsigned          row_cnt;
    out_item_t            smoothed_q[$];
    int                   errors;

    function new();
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      k_center   = RST_COEF_CENTER;
      k_edge     = RST_COEF_EDGE;
      k_corner   = RST_COEF_CORNER;
      col_cnt    = 0;
      row_cnt    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = val[SIZE_W-1:0];
        end
        REG_FRAME_HEIGHT: begin
          height_reg = val[SIZE_W-1:0];
        end
        REG_COEF_CENTER: begin
          k_center = val[COEF_W-1:0];
        end
        REG_COEF_EDGE: begin
          k_edge = val[COEF_W-1:0];
        end
        REG_COEF_CORNER: begin
          k_corner = val[COEF_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned cur_width();
      return effective_size(width_reg, LINE_MAX);
    endfunction

    function bit in_flush_row();
      return row_cnt >= effective_size(height_reg, ROWS_MAX);
    endfunction

    function bit at_frame_start();
      return row_cnt == 0 && col_cnt == 0;
    endfunction

    function int unsigned frame_items();
      return (effective_size(height_reg, ROWS_MAX) + 1) * cur_width();
    endfunction

    function int pending();
      return smoothed_q.size();
    endfunction

    // mask over window columns f, f+1, f+2, centered on column f+1
    function bit [PIX_W-1:0] weigh(int f);
      longint unsigned orth;
      longint unsigned diag;
      longint unsigned acc;
      longint unsigned res;
      orth = longint'(win[f+1][0]) + win[f+1][2] + win[f][1] + win[f+2][1];
      diag = longint'(win[f][0]) + win[f][2] + win[f+2][0] + win[f+2][2];
      acc  = longint'(win[f+1][1]) * k_center + orth * k_edge + diag * k_corner;
      res  = (acc + 32768) >> 16;
      return (res > 255) ? 8'd255 : res[PIX_W-1:0];
    endfunction

    function void push_word(bit [PIX_W-1:0] pix, bit last_of_frame);
      out_item_t e;
      e.pixel_out  = pix;
      e.frame_last = last_of_frame;
      smoothed_q.insert(smoothed_q.size(), e);
    endfunction

    function void take_pixel(in_item_t w);
      int unsigned    wd;
      int unsigned    c;
      int unsigned    r;
      int unsigned    slot;
      bit             flush;
      bit             last;
      bit [PIX_W-1:0] v;
      bit [PIX_W-1:0] up;
      bit [PIX_W-1:0] mid;
      wd    = cur_width();
      c     = col_cnt;
      r     = row_cnt;
      flush = in_flush_row();
      last  = (c + 1 >= wd);
      slot  = (c < LINE_MAX) ? c : LINE_MAX - 1;
      // padding in a real row and anything in the flush row count as black
      v     = (flush || w.req_type) ? '0 : w.pixel_in;
      up    = (r >= 2) ? two_up[slot] : '0;
      mid   = (r >= 1) ? one_up[slot] : '0;
      two_up[slot] = one_up[slot];
      one_up[slot] = v;

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (c == 0) begin
            win[i][j] = '0;
          end else if (i < 2) begin
            win[i][j] = win[i+1][j];
          end
        end
      end
      win[2][0] = up;
      win[2][1] = mid;
      win[2][2] = v;

      if (r >= 1) begin
        if (c >= 1) push_word(weigh(0), 1'b0);
        // the row's last pixel leaves with its left neighbor
        if (last) push_word(weigh(1), flush);
      end

      if (last) begin
        col_cnt = 0;
        row_cnt = flush ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t want;
      if (smoothed_q.size() == 0) begin
        $error("unexpected result word: pixel_out %0d, frame_last %0d",
               got.pixel_out, got.frame_last);
        errors++;
        return;
      end
      want = smoothed_q.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $error("pixel_out: expected %0d, got %0d", want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of gaussian_blur_3x3_unit: short hand-picked frames for the
// borders, saturation, size clamping, padding words and register changes in
// the middle of a frame, two frames with oversized registers cut short, then
// random frames with random or reset masks. Both channels idle at random but
// in the wide run; every result word is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gb3_pkg::*;
  import blur_check_pkg::*;

  localparam int   IDLE_PCT      = 17;
  localparam int   NOISE_PCT     = 5;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   RANDOM_WORDS  = 400;
  localparam int   WIDE_RUN      = 150;
  localparam int   TALL_RUN      = 200;
  localparam logic KIND_PIXEL    = 1'b0;
  localparam logic KIND_PAD      = 1'b1;

  // 3x2 frame: extremes, padding inside a real row, a pixel inside the flush row
  localparam in_item_t BORDER_WORDS [9] = '{
    '{KIND_PIXEL, 8'd255}, '{KIND_PIXEL, 8'd0},  '{KIND_PIXEL, 8'd255},
    '{KIND_PIXEL, 8'd0},   '{KIND_PAD, 8'd200},  '{KIND_PIXEL, 8'd255},
    '{KIND_PAD, 8'd0},     '{KIND_PIXEL, 8'd77}, '{KIND_PAD, 8'd255}
  };
  // 2x1 frame under a full-scale mask
  localparam in_item_t SATURATE_WORDS [4] = '{
    '{KIND_PIXEL, 8'd255}, '{KIND_PIXEL, 8'd255}, '{KIND_PAD, 8'd0}, '{KIND_PAD, 8'd0}
  };
  // single-column frame, two rows
  localparam in_item_t COLUMN_WORDS [3] = '{
    '{KIND_PIXEL, 8'd1}, '{KIND_PIXEL, 8'd128}, '{KIND_PAD, 8'd0}
  };

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit             calm     = 1'b0;
  int             words_in = 0;
  blur_scoreboard sb;

  gaussian_blur_3x3_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_data);
  end

  function automatic in_item_t next_word();
    in_item_t w;
    w.req_type = sb.in_flush_row() ? KIND_PAD : KIND_PIXEL;
    if ($urandom_range(99) < NOISE_PCT) w.req_type = ~w.req_type;
    case ($urandom_range(7))
      0: w.pixel_in = '0;
      1: w.pixel_in = '1;
      default: w.pixel_in = PIX_W'($urandom);
    endcase
    return w;
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return COEF_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_word(input in_item_t w);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    // hold the word until the unit takes it
    do @(posedge clk); while (in_stall);
    sb.take_pixel(w);
    words_in++;
  endtask

  // count of zero: run on to the end of the current frame
  task automatic feed(input int count);
    int n;
    n = 0;
    do begin
      send_word(next_word());
      n++;
    end while (count > 0 ? n < count : !sb.at_frame_start());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    // a word that releases nothing may still be in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned fw, input int unsigned fh,
                           input logic [COEF_W-1:0] cc, input logic [COEF_W-1:0] ce,
                           input logic [COEF_W-1:0] ck);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(fw));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(fh));
    write_reg(REG_COEF_CENTER, cc);
    write_reg(REG_COEF_EDGE, ce);
    write_reg(REG_COEF_CORNER, ck);
  endtask

  initial begin
    int unsigned          fw;
    int unsigned          fh;
    int                   random_goal;
    logic [CFG_IDX_W-1:0] which;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    configure(3, 2, RST_COEF_CENTER, RST_COEF_EDGE, RST_COEF_CORNER);
    foreach (BORDER_WORDS[i]) send_word(BORDER_WORDS[i]);

    // height zero acts as one
    configure(2, 0, '1, '1, '1);
    foreach (SATURATE_WORDS[i]) send_word(SATURATE_WORDS[i]);

    configure(0, 2, RST_COEF_CENTER, RST_COEF_EDGE, RST_COEF_CORNER);
    foreach (COLUMN_WORDS[i]) send_word(COLUMN_WORDS[i]);

    // registers changed inside a frame
    configure(4, 3, '0, '0, '0);
    feed(6);
    wait_idle();
    write_reg(REG_COEF_CENTER, '1);
    // column count already at the new width: the next word ends the row
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    feed(1);
    wait_idle();
    // row two now lies past the frame and becomes the flush row
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
    feed(0);

    // oversized registers, each frame cut short; the wide row runs with no idling at all
    calm <= 1'b1;
    configure(2047, 1, RST_COEF_CENTER, RST_COEF_EDGE, RST_COEF_CORNER);
    feed(WIDE_RUN);
    wait_idle();
    // column count past the new width: the next word ends the row
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
    feed(0);
    wait_idle();
    calm <= 1'b0;
    configure(1, 2047, '1, '0, random_coef());
    feed(TALL_RUN);
    wait_idle();
    // row count past the new height: the next row is the flush row
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    feed(0);

    random_goal = words_in + RANDOM_WORDS;
    while (words_in < random_goal) begin
      fw = ($urandom_range(9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      fh = ($urandom_range(9) < 7) ? $urandom_range(0, 5) : $urandom_range(6, 12);
      if ($urandom_range(4) == 0) begin
        configure(fw, fh, RST_COEF_CENTER, RST_COEF_EDGE, RST_COEF_CORNER);
      end else begin
        configure(fw, fh, random_coef(), random_coef(), random_coef());
      end
      if ($urandom_range(3) == 0 && sb.frame_items() > 1) begin
        feed($urandom_range(1, sb.frame_items() - 1));
        wait_idle();
        case ($urandom_range(2))
          0: begin
            case ($urandom_range(2))
              0: which = REG_COEF_CENTER;
              1: which = REG_COEF_EDGE;
              default: which = REG_COEF_CORNER;
            endcase
            write_reg(which, random_coef());
          end
          1: begin
            // no wider than now: a wider row would read line buffer entries never written
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(0, sb.cur_width())));
          end
          default: begin
            write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
          end
        endcase
      end
      feed(0);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/gb3_pkg.sv
hdl/gb3_line_buf.sv
hdl/gb3_window.sv
hdl/gb3_mac.sv
hdl/gb3_out_fifo.sv
hdl/gaussian_blur_3x3_unit.sv
verif/blur_check_pkg.sv
verif/tb.sv
